// ===== rtl/core/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared widths, constants, types and register indexes of the line-follow
// PID drive controller.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  // Field widths of the stream and configuration channels.
  localparam int POS_W     = 13;
  localparam int ERR_W     = 13;
  localparam int DRIVE_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int LEVEL_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int IN_DAT_W  = 16;
  localparam int OUT_DAT_W = 32;

  // Fraction bits of the Q8.8 gains.
  localparam int FRAC_W = 8;

  // Line position that means the sensor is centered, and its upper bound.
  localparam logic [POS_W-1:0] CENTER_POS = 13'd4000;
  localparam logic [POS_W-1:0] POS_MAX    = 13'd8000;

  // Register indexes of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd6;

  // Reset values of the drive levels and limits.
  localparam logic [LEVEL_W-1:0] BASE_RIGHT_RST  = 8'd37;
  localparam logic [LEVEL_W-1:0] BASE_LEFT_RST   = 8'd35;
  localparam logic [LEVEL_W-1:0] RIGHT_LIMIT_RST = 8'd70;
  localparam logic [LEVEL_W-1:0] LEFT_LIMIT_RST  = 8'd75;

  typedef logic [CFG_IDX_W-1:0]        cfg_index_t;
  typedef logic [CFG_DAT_W-1:0]        cfg_data_t;
  typedef logic [IN_DAT_W-1:0]         in_data_t;
  typedef logic [OUT_DAT_W-1:0]        out_data_t;
  typedef logic signed [ERR_W-1:0]     err_t;
  typedef logic [GAIN_W-1:0]           gain_t;
  typedef logic [LEVEL_W-1:0]          level_t;

endpackage

// ===== rtl/core/line_follow_pid_drive.sv =====
// ----------------------------------------------------------------------------
// line_follow_pid_drive
// PID steering of a two-motor line follower: one position request in, one
// pair of motor commands out.
// ----------------------------------------------------------------------------
module line_follow_pid_drive #(
  parameter int WINDOW_TAPS = 5
) (
  input  logic                clk,
  input  logic                rst,
  // Position requests.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  lfpd_pkg::in_data_t  s_tdata,    // [12:0] position, [15:13] zero
  // Motor command results.
  output logic                m_tvalid,
  input  logic                m_tready,
  output lfpd_pkg::out_data_t m_tdata,    // [15:0] right_drive, [31:16] left_drive
  // Configuration writes.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  lfpd_pkg::cfg_index_t cfg_index,
  input  lfpd_pkg::cfg_data_t cfg_data
);

  // The block accepts one position request per clock while its output is not
  // stalled, and returns one pair of motor commands per request. The datapath is a
  // five-register pipeline (input, error window, gain products, steering sum,
  // drive output) that advances as a whole whenever the output register is
  // empty or its result is being taken, so s_tready follows m_tready with no
  // wait states. A running sum of the stored errors keeps the integral window
  // to one add per request at any window length. Configuration writes are
  // taken every cycle and are meant for times when no request is in flight.

  import lfpd_pkg::*;

  localparam int DEPTH    = WINDOW_TAPS - 1;
  localparam int SUM_W    = ERR_W + $clog2(WINDOW_TAPS);
  localparam int DIFF_W   = ERR_W + 1;
  localparam int GS_W     = GAIN_W + 1;
  localparam int PP_W     = ERR_W + GS_W;
  localparam int PI_W     = SUM_W + GS_W;
  localparam int PD_W     = DIFF_W + GS_W;
  localparam int STEER_W  = SUM_W + GS_W - FRAC_W + 2;
  localparam int DRV_W    = STEER_W + 1;
  localparam logic signed [DRV_W-1:0] DRV_MIN = -DRV_W'(32'sd32768);

  // Configuration registers.
  level_t base_right;
  level_t base_left;
  level_t right_drive_limit;
  level_t left_drive_limit;
  gain_t  gain_prop;
  gain_t  gain_integ;
  gain_t  gain_deriv;

  // Pipeline control.
  logic advance;
  logic va, vb, vc, vd;

  // Stage payloads.
  logic [POS_W-1:0]         pos_a;
  err_t                     err_b;
  logic signed [SUM_W-1:0]  wsum_b;
  logic signed [DIFF_W-1:0] diff_b;
  logic signed [PP_W-1:0]   prod_p_c;
  logic signed [PI_W-1:0]   prod_i_c;
  logic signed [PD_W-1:0]   prod_d_c;
  logic signed [STEER_W-1:0] steer_d;

  // Error history, newest first, and the running sum of its entries.
  err_t                    hist [DEPTH];
  logic signed [SUM_W-1:0] hist_sum;

  // Stage A combinational values.
  logic [POS_W-1:0]         pos_sat;
  logic [DIFF_W-1:0]        err_wide;
  err_t                     err_a;
  logic signed [SUM_W-1:0]  err_ext;
  logic signed [SUM_W-1:0]  old_ext;
  logic signed [SUM_W-1:0]  wsum_next;
  logic signed [DIFF_W-1:0] diff_next;
  logic signed [SUM_W-1:0]  hist_sum_next;

  // Stage D and output combinational values.
  logic [PP_W-1:0]           adj_p;
  logic [PI_W-1:0]           adj_i;
  logic [PD_W-1:0]           adj_d;
  logic signed [STEER_W-1:0] term_p;
  logic signed [STEER_W-1:0] term_i;
  logic signed [STEER_W-1:0] term_d;
  logic signed [STEER_W-1:0] steer_next;
  logic signed [DRV_W-1:0]   right_v;
  logic signed [DRV_W-1:0]   left_v;
  logic signed [DRV_W-1:0]   right_lim;
  logic signed [DRV_W-1:0]   left_lim;
  logic [DRIVE_W-1:0]        right_drive;
  logic [DRIVE_W-1:0]        left_drive;

  // The whole pipeline moves when the output register can take a result.
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign cfg_ready = 1'b1;

  // Configuration register file; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_right        <= BASE_RIGHT_RST;
      base_left         <= BASE_LEFT_RST;
      right_drive_limit <= RIGHT_LIMIT_RST;
      left_drive_limit  <= LEFT_LIMIT_RST;
      gain_prop         <= '0;
      gain_integ        <= '0;
      gain_deriv        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_RIGHT:  base_right        <= cfg_data[LEVEL_W-1:0];
        REG_BASE_LEFT:   base_left         <= cfg_data[LEVEL_W-1:0];
        REG_RIGHT_LIMIT: right_drive_limit <= cfg_data[LEVEL_W-1:0];
        REG_LEFT_LIMIT:  left_drive_limit  <= cfg_data[LEVEL_W-1:0];
        REG_GAIN_PROP:   gain_prop         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG:  gain_integ        <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV:  gain_deriv        <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      vd       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      va       <= s_tvalid;
      vb       <= va;
      vc       <= vb;
      vd       <= vc;
      m_tvalid <= vd;
    end
  end

  // Stage A: saturate the position and form the error, window sum and
  // difference against the newest stored error.
  always_comb begin
    pos_sat       = (pos_a > POS_MAX) ? POS_MAX : pos_a;
    err_wide      = {1'b0, CENTER_POS} - {1'b0, pos_sat};
    err_a         = err_t'(err_wide[ERR_W-1:0]);
    err_ext       = {{(SUM_W-ERR_W){err_a[ERR_W-1]}}, err_a};
    old_ext       = {{(SUM_W-ERR_W){hist[DEPTH-1][ERR_W-1]}}, hist[DEPTH-1]};
    wsum_next     = err_ext + hist_sum;
    diff_next     = {err_a[ERR_W-1], err_a} - {hist[0][ERR_W-1], hist[0]};
    hist_sum_next = wsum_next - old_ext;
  end

  // Error history shift and running sum, updated as each request leaves A.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist[i] <= '0;
      end
      hist_sum <= '0;
    end else if (advance && va) begin
      for (int i = DEPTH - 1; i > 0; i--) begin
        hist[i] <= hist[i-1];
      end
      hist[0]  <= err_a;
      hist_sum <= hist_sum_next;
    end
  end

  // Datapath registers; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      pos_a    <= s_tdata[POS_W-1:0];
      err_b    <= err_a;
      wsum_b   <= wsum_next;
      diff_b   <= diff_next;
      prod_p_c <= PP_W'(err_b) * PP_W'($signed({1'b0, gain_prop}));
      prod_i_c <= PI_W'(wsum_b) * PI_W'($signed({1'b0, gain_integ}));
      prod_d_c <= PD_W'(diff_b) * PD_W'($signed({1'b0, gain_deriv}));
      steer_d  <= steer_next;
      m_tdata  <= {left_drive, right_drive};
    end
  end

  // Stage D: divide each product by 256 rounding toward zero, then sum.
  always_comb begin
    adj_p = prod_p_c + {{(PP_W-FRAC_W){1'b0}}, {FRAC_W{prod_p_c[PP_W-1]}}};
    adj_i = prod_i_c + {{(PI_W-FRAC_W){1'b0}}, {FRAC_W{prod_i_c[PI_W-1]}}};
    adj_d = prod_d_c + {{(PD_W-FRAC_W){1'b0}}, {FRAC_W{prod_d_c[PD_W-1]}}};
    term_p = {{(STEER_W-PP_W+FRAC_W){adj_p[PP_W-1]}}, adj_p[PP_W-1:FRAC_W]};
    term_i = {{(STEER_W-PI_W+FRAC_W){adj_i[PI_W-1]}}, adj_i[PI_W-1:FRAC_W]};
    term_d = {{(STEER_W-PD_W+FRAC_W){adj_d[PD_W-1]}}, adj_d[PD_W-1:FRAC_W]};
    steer_next = term_p + term_i + term_d;
  end

  // Output stage: steer both motors and clamp to the limit and the floor.
  always_comb begin
    right_v   = {{(DRV_W-LEVEL_W){1'b0}}, base_right} - DRV_W'(steer_d);
    left_v    = {{(DRV_W-LEVEL_W){1'b0}}, base_left} + DRV_W'(steer_d);
    right_lim = {{(DRV_W-LEVEL_W){1'b0}}, right_drive_limit};
    left_lim  = {{(DRV_W-LEVEL_W){1'b0}}, left_drive_limit};
    if (right_v > right_lim) begin
      right_drive = right_lim[DRIVE_W-1:0];
    end else if (right_v < DRV_MIN) begin
      right_drive = DRV_MIN[DRIVE_W-1:0];
    end else begin
      right_drive = right_v[DRIVE_W-1:0];
    end
    if (left_v > left_lim) begin
      left_drive = left_lim[DRIVE_W-1:0];
    end else if (left_v < DRV_MIN) begin
      left_drive = DRV_MIN[DRIVE_W-1:0];
    end else begin
      left_drive = left_v[DRIVE_W-1:0];
    end
  end

  // A request in stage A always reaches stage B on an advance.
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (advance && va) |=> vb)
    else $error("request lost between input and error stage");

  // A result appears only when the steering stage held a request.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vd))
    else $error("result raised without a request in the steering stage");

  // The error after saturation stays within the centered range.
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    vb |-> (err_b >= -13'sd4000 && err_b <= 13'sd4000))
    else $error("error outside of -4000..4000");

  // The running history sum stays within what its entries can add up to.
  a_hist_sum_range: assert property (@(posedge clk) disable iff (rst)
    (hist_sum >= -SUM_W'(4000 * DEPTH) && hist_sum <= SUM_W'(4000 * DEPTH)))
    else $error("running error sum out of range");

endmodule

// ===== dv/line_follow_pid_drive_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_drive_test
// Self-checking bench for the line-follow PID drive controller. A table of
// directed requests runs first. Random position walks follow under several
// register settings and idle patterns. Every motor command pair is checked
// against a predictor held in this file, or against the table's own values.
// ----------------------------------------------------------------------------
module line_follow_pid_drive_test;
  import lfpd_pkg::*;

  localparam int TAPS         = 5;
  localparam int HIST_DEPTH   = TAPS - 1;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int SEG_ITEMS    = 100;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;

  // Index with no register behind it; writes to it must be ignored.
  localparam cfg_index_t REG_UNUSED = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_POS} row_kind_t;

  // Packed like m_tdata: right drive low, left drive high.
  typedef struct packed {
    logic [DRIVE_W-1:0] left;
    logic [DRIVE_W-1:0] right;
  } drive_pair_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_index_t  idx;
    logic [15:0] value;
    logic        has_exp;
    drive_pair_t exp;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  in_data_t    s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  out_data_t   m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = '0;
  cfg_data_t   cfg_data = '0;

  // Predictor copy of the registers and the error history.
  level_t      base_right  = BASE_RIGHT_RST;
  level_t      base_left   = BASE_LEFT_RST;
  level_t      right_limit = RIGHT_LIMIT_RST;
  level_t      left_limit  = LEFT_LIMIT_RST;
  gain_t       gain_prop   = '0;
  gain_t       gain_integ  = '0;
  gain_t       gain_deriv  = '0;
  err_t        err_hist [HIST_DEPTH] = '{default: '0};

  drive_pair_t drive_q [$];
  plan_row_t   plan [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off      = 1'b0;
  int walk_pos      = 4000;
  int cycle_count   = 0;
  int mismatches    = 0;
  int positions_in  = 0;
  int results_seen  = 0;
  int writes_done   = 0;

  line_follow_pid_drive #(.WINDOW_TAPS(TAPS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Q8.8 gain applied to a signed value; division truncates toward zero.
  function automatic longint scaled_term(input longint v, input gain_t g);
    return (v * longint'(g)) / 256;
  endfunction

  // Upper clamp at the limit register, lower saturation at -32768.
  function automatic logic [DRIVE_W-1:0] clamp_drive(input longint v, input level_t lim);
    if (v > longint'(lim)) v = longint'(lim);
    if (v < -32768) v = -32768;
    return v[DRIVE_W-1:0];
  endfunction

  // Motor commands for one position; shifts the new error into the history.
  function automatic drive_pair_t predict_drives(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] p;
    longint           err;
    longint           win;
    longint           steer;
    drive_pair_t      d;
    p = (pos > POS_MAX) ? POS_MAX : pos;
    err = longint'(CENTER_POS) - longint'(p);
    win = err;
    for (int i = 0; i < HIST_DEPTH; i++) win += longint'(err_hist[i]);
    steer = scaled_term(err, gain_prop) + scaled_term(win, gain_integ)
          + scaled_term(err - longint'(err_hist[0]), gain_deriv);
    for (int i = HIST_DEPTH - 1; i > 0; i--) err_hist[i] = err_hist[i-1];
    err_hist[0] = err_t'(err);
    d.right = clamp_drive(longint'(base_right) - steer, right_limit);
    d.left  = clamp_drive(longint'(base_left) + steer, left_limit);
    return d;
  endfunction

  // Mirrors a register write into the predictor; only the low bits of the levels are kept.
  function automatic void apply_write(input cfg_index_t idx, input cfg_data_t data);
    case (idx)
      REG_BASE_RIGHT:  base_right  = data[LEVEL_W-1:0];
      REG_BASE_LEFT:   base_left   = data[LEVEL_W-1:0];
      REG_RIGHT_LIMIT: right_limit = data[LEVEL_W-1:0];
      REG_LEFT_LIMIT:  left_limit  = data[LEVEL_W-1:0];
      REG_GAIN_PROP:   gain_prop   = data;
      REG_GAIN_INTEG:  gain_integ  = data;
      REG_GAIN_DERIV:  gain_deriv  = data;
      default: ;
    endcase
  endfunction

  // Mostly a drifting line around the center, with jumps and over-range noise.
  function automatic logic [POS_W-1:0] next_position();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      walk_pos += $urandom_range(0, 800) - 400;
      if (walk_pos < 0) walk_pos = 0;
      if (walk_pos > 8000) walk_pos = 8000;
      return walk_pos[POS_W-1:0];
    end else if (pick < 17) begin
      return POS_W'($urandom_range(0, 8191));
    end else if (pick < 19) begin
      return $urandom_range(0, 1) ? POS_MAX : '0;
    end
    return POS_W'($urandom_range(8001, 8191));
  endfunction

  function automatic plan_row_t pos_row(input int pos);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_POS;
    r.value = 16'(pos);
    return r;
  endfunction

  function automatic plan_row_t pos_chk(input int pos, input int right, input int left);
    plan_row_t r;
    r = pos_row(pos);
    r.has_exp   = 1'b1;
    r.exp.right = 16'(right);
    r.exp.left  = 16'(left);
    return r;
  endfunction

  function automatic plan_row_t wr_row(input cfg_index_t idx, input int value);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = 16'(value);
    return r;
  endfunction

  // One position request; called and returns at a falling edge.
  task automatic send_position(input logic [POS_W-1:0] pos, input logic has_exp,
                               input drive_pair_t typed);
    drive_pair_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DAT_W-POS_W){1'b0}}, pos};
    do @(posedge clk); while (!s_tready);
    pred = predict_drives(pos);
    drive_q.push_back(has_exp ? typed : pred);
    positions_in++;
    @(negedge clk);
  endtask

  // One register write; leaves cfg_valid high for a following write.
  task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_write(idx, data);
    writes_done++;
    @(negedge clk);
  endtask

  // Waits until every command pair has come back, then for the pipeline tail.
  task automatic drain();
    while (drive_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes every register, either at random or at its extremes.
  task automatic load_settings(input bit extreme);
    cfg_data_t lv [4];
    cfg_data_t gn [3];
    for (int i = 0; i < 4; i++) begin
      lv[i] = cfg_data_t'($urandom_range(0, 65535));
      if (extreme) lv[i][LEVEL_W-1:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    for (int i = 0; i < 3; i++) begin
      if (extreme) gn[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else if ($urandom_range(0, 3) == 0) gn[i] = cfg_data_t'($urandom_range(0, 65535));
      else gn[i] = cfg_data_t'($urandom_range(0, 'h300));
    end
    write_reg(REG_BASE_RIGHT, lv[0]);
    write_reg(REG_BASE_LEFT, lv[1]);
    write_reg(REG_RIGHT_LIMIT, lv[2]);
    write_reg(REG_LEFT_LIMIT, lv[3]);
    write_reg(REG_GAIN_PROP, gn[0]);
    write_reg(REG_GAIN_INTEG, gn[1]);
    write_reg(REG_GAIN_DERIV, gn[2]);
    write_reg(REG_UNUSED, cfg_data_t'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_segment(input int n);
    repeat (n) send_position(next_position(), 1'b0, '0);
    s_tvalid <= 1'b0;
  endtask

  task automatic note_mismatch(input string field, input logic signed [DRIVE_W-1:0] want,
                               input logic signed [DRIVE_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               field, results_seen, want, got);
  endtask

  // Receiver readiness, with an optional long hold-off.
  always @(negedge clk) begin
    m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compares each accepted command pair with the oldest expectation.
  always @(posedge clk) begin
    drive_pair_t got;
    drive_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      if (drive_q.size() == 0) begin
        note_mismatch("unrequested right_drive", '0, got.right);
      end else begin
        want = drive_q.pop_front();
        if (got.right !== want.right) note_mismatch("right_drive", want.right, got.right);
        if (got.left !== want.left) note_mismatch("left_drive", want.left, got.left);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d results pending",
               cycle_count, drive_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    bit prev_write;

    // Reset values, register masking and the ignored index first; then
    // unit gain, the largest gains, small gains and zero limits.
    plan.push_back(pos_chk(4000, 37, 35));
    plan.push_back(pos_chk(0, 37, 35));
    plan.push_back(pos_chk(8000, 37, 35));
    plan.push_back(pos_chk(8191, 37, 35));
    plan.push_back(wr_row(REG_UNUSED, 'hFFFF));
    plan.push_back(pos_chk(5000, 37, 35));
    plan.push_back(wr_row(REG_BASE_RIGHT, 'h01FF));
    plan.push_back(wr_row(REG_BASE_LEFT, 'hFF00));
    plan.push_back(pos_chk(3000, 70, 0));
    plan.push_back(wr_row(REG_RIGHT_LIMIT, 'hAAFF));
    plan.push_back(wr_row(REG_LEFT_LIMIT, 'h00FF));
    plan.push_back(pos_chk(1234, 255, 0));
    plan.push_back(wr_row(REG_GAIN_PROP, 'h0100));
    plan.push_back(pos_chk(4000, 255, 0));
    plan.push_back(pos_chk(0, -3745, 255));
    plan.push_back(pos_chk(8000, 255, -4000));
    plan.push_back(wr_row(REG_GAIN_INTEG, 'hFFFF));
    plan.push_back(wr_row(REG_GAIN_DERIV, 'hFFFF));
    plan.push_back(wr_row(REG_GAIN_PROP, 'hFFFF));
    plan.push_back(pos_row(0));
    plan.push_back(pos_row(8191));
    plan.push_back(pos_row(4001));
    plan.push_back(pos_row(3999));
    plan.push_back(wr_row(REG_GAIN_PROP, 'h0001));
    plan.push_back(wr_row(REG_GAIN_INTEG, 'h0003));
    plan.push_back(wr_row(REG_GAIN_DERIV, 'h0081));
    plan.push_back(pos_row(4001));
    plan.push_back(pos_row(3999));
    plan.push_back(pos_row(4255));
    plan.push_back(pos_row(3745));
    plan.push_back(wr_row(REG_RIGHT_LIMIT, 0));
    plan.push_back(wr_row(REG_LEFT_LIMIT, 0));
    plan.push_back(wr_row(REG_BASE_RIGHT, 0));
    plan.push_back(pos_row(0));
    plan.push_back(pos_row(8000));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table, under the first idle pattern.
    send_idle_pct = 35;
    recv_idle_pct = 74;
    prev_write = 1'b0;
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!prev_write) begin
          s_tvalid <= 1'b0;
          drain();
        end
        write_reg(plan[i].idx, plan[i].value);
        if (i + 1 == plan.size() || plan[i+1].kind != ROW_WRITE) cfg_valid <= 1'b0;
        prev_write = 1'b1;
      end else begin
        send_position(plan[i].value[POS_W-1:0], plan[i].has_exp, plan[i].exp);
        prev_write = 1'b0;
      end
    end
    s_tvalid <= 1'b0;
    drain();

    // Random walks: two settings per idle pattern, extremes among them.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 35 : 0;
      for (int half = 0; half < 2; half++) begin
        load_settings(half == 1 && phase != 1);
        if (phase == 2 && half == 0) begin
          // Receiver stalls long enough for the block to back up its input.
          fork
            begin
              hold_off = 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk);
              hold_off = 1'b0;
            end
            run_segment(SEG_ITEMS);
          join
        end else begin
          run_segment(SEG_ITEMS);
        end
        drain();
      end
    end

    $display("Checked %0d motor command pairs for %0d position requests and %0d writes,",
             results_seen, positions_in, writes_done);
    $display("covering reset values, saturation, extreme gains and long output stalls.");
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
